@@ rtl/wctu_pkg.sv @@
// Package: shared types, constants and the UTF-8 byte builder for the wide-char encoder.
`timescale 1ns / 1ps
package wctu_pkg;

  localparam int JOBQ_DEPTH = 2;
  localparam int SEQ_BYTES  = 4;
  localparam int JOB_BYTES  = 7;

  localparam logic [5:0]  HIGH_SURR_TAG = 6'b110110;  // 0xD800 under 0xFC00
  localparam logic [5:0]  LOW_SURR_TAG  = 6'b110111;  // 0xDC00 under 0xFC00
  localparam logic [15:0] PLANE_TOP     = 16'h0010;   // upper half of 0x10FFFF
  localparam logic [7:0]  LEAD4         = 8'hF0;
  localparam logic [7:0]  LEAD3         = 8'hE0;
  localparam logic [2:0]  LEAD2_TAG     = 3'b110;     // 0xC0
  localparam logic [1:0]  CONT_TAG      = 2'b10;      // 0x80
  localparam logic [20:0] SUPP_BASE     = 21'h10000;

  // One UTF-8 sequence, unused bytes held at zero
  typedef struct packed {
    logic [0:SEQ_BYTES-1][7:0] bytes;
    logic [2:0]                len;
  } seq_t;

  // All bytes caused by one accepted unit; terminator (if any) is the last counted byte
  typedef struct packed {
    logic [0:JOB_BYTES-1][7:0] bytes;
    logic [2:0]                count;
    logic                      term;
  } job_t;

  function automatic seq_t encode(input logic [31:0] v, input logic four);
    seq_t s;
    s = '0;
    if (four) begin
      s.bytes[0] = LEAD4 | {5'd0, v[20:18]};
      s.bytes[1] = {CONT_TAG, v[17:12]};
      s.bytes[2] = {CONT_TAG, v[11:6]};
      s.bytes[3] = {CONT_TAG, v[5:0]};
      s.len      = 3'd4;
    end else if (v[31:7] == '0) begin
      s.bytes[0] = {1'b0, v[6:0]};
      s.len      = 3'd1;
    end else if (v[31:11] == '0) begin
      s.bytes[0] = {LEAD2_TAG, v[10:6]};
      s.bytes[1] = {CONT_TAG, v[5:0]};
      s.len      = 3'd2;
    end else begin
      // out-of-range values keep bits 19..12 in the lead byte
      s.bytes[0] = LEAD3 | v[19:12];
      s.bytes[1] = {CONT_TAG, v[11:6]};
      s.bytes[2] = {CONT_TAG, v[5:0]};
      s.len      = 3'd3;
    end
    return s;
  endfunction

endpackage

@@ rtl/wctu_front.sv @@
// Front end: accepts units, tracks surrogate/string state and builds at most one byte job per unit.
`timescale 1ns / 1ps
module wctu_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            unit_mode_we,
  input  logic            unit_mode_wdata,
  input  logic            in_take,
  input  logic [31:0]     code_unit,
  input  logic            last_unit,
  output logic            job_push,
  output wctu_pkg::job_t  job
);

  logic        mode;
  logic        holding, holding_next;
  logic [15:0] held, held_next;
  logic        string_ended, string_ended_next;

  logic          has_a;
  wctu_pkg::seq_t seq_a, seq_b;
  logic [15:0]   u16;
  logic [20:0]   cp;
  logic          four32;

  always_comb begin
    u16    = code_unit[15:0];
    cp     = wctu_pkg::SUPP_BASE + {1'b0, held[9:0], u16[9:0]};
    four32 = (code_unit[31:16] != '0) && (code_unit[31:16] <= wctu_pkg::PLANE_TOP);
    seq_a  = wctu_pkg::encode({16'd0, held}, 1'b0);
  end

  always_comb begin
    holding_next      = holding;
    held_next         = held;
    string_ended_next = string_ended;
    has_a             = 1'b0;
    seq_b             = '0;
    job.term          = 1'b0;
    if (string_ended) begin
      if (last_unit) string_ended_next = 1'b0;
    end else if (!mode) begin
      if (holding && u16[15:10] == wctu_pkg::LOW_SURR_TAG) begin
        holding_next = 1'b0;
        held_next    = '0;
        seq_b        = wctu_pkg::encode({11'd0, cp}, 1'b1);
        job.term     = last_unit;
      end else begin
        has_a        = holding;
        holding_next = 1'b0;
        held_next    = '0;
        if (u16 == '0) begin
          job.term          = 1'b1;
          string_ended_next = !last_unit;
        end else if (u16[15:10] == wctu_pkg::HIGH_SURR_TAG && !last_unit) begin
          holding_next = 1'b1;
          held_next    = u16;
        end else begin
          seq_b    = wctu_pkg::encode({16'd0, u16}, 1'b0);
          job.term = last_unit;
        end
      end
    end else begin
      if (code_unit == '0) begin
        job.term          = 1'b1;
        string_ended_next = !last_unit;
      end else begin
        seq_b    = wctu_pkg::encode(code_unit, four32);
        job.term = last_unit;
      end
    end
    job.count = (has_a ? 3'd3 : 3'd0) + seq_b.len + {2'd0, job.term};
    if (has_a) begin
      job.bytes = {seq_a.bytes[0:2], seq_b.bytes};
    end else begin
      job.bytes = {seq_b.bytes, 24'd0};
    end
    job_push = in_take && (job.count != 3'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= 1'b0;
      holding      <= 1'b0;
      held         <= '0;
      string_ended <= 1'b0;
    end else if (unit_mode_we) begin
      // mode change drops any held high surrogate silently
      mode    <= unit_mode_wdata;
      holding <= 1'b0;
      held    <= '0;
    end else if (in_take) begin
      holding      <= holding_next;
      held         <= held_next;
      string_ended <= string_ended_next;
    end
  end

endmodule

@@ rtl/wctu_jobq.sv @@
// Job queue: short FIFO of byte jobs between front end and serialiser.
`timescale 1ns / 1ps
module wctu_jobq (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  wctu_pkg::job_t  push_job,
  output logic            full,
  input  logic            pop,
  output logic            q_valid,
  output wctu_pkg::job_t  q_job
);

  localparam int DEPTH = wctu_pkg::JOBQ_DEPTH;
  localparam int AW    = $clog2(DEPTH);

  wctu_pkg::job_t  slots [DEPTH];
  logic [AW-1:0]   wptr, rptr;
  logic [AW:0]     cnt, cnt_next;
  logic            do_push, do_pop;

  always_comb begin
    full     = (cnt == (AW+1)'(DEPTH));
    q_valid  = (cnt != '0);
    q_job    = slots[rptr];
    do_push  = push && !full;
    do_pop   = pop && q_valid;
    cnt_next = cnt + {{AW{1'b0}}, do_push} - {{AW{1'b0}}, do_pop};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      if (do_push) wptr <= wptr + 1'b1;
      if (do_pop)  rptr <= rptr + 1'b1;
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wptr] <= push_job;
  end

endmodule

@@ rtl/wctu_back.sv @@
// Serialiser: walks the current job one byte per cycle onto the result port while pop is held.
`timescale 1ns / 1ps
module wctu_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  wctu_pkg::job_t  q_job,
  output logic            q_pop,
  output logic [7:0]      out_byte,
  output logic            end_of_text,
  output logic            empty,
  input  logic            pop
);

  wctu_pkg::job_t cur;
  logic           cur_valid;
  logic [2:0]     idx;
  logic           at_last, load;

  always_comb begin
    at_last     = (idx == cur.count - 3'd1);
    load        = !cur_valid || (pop && at_last);
    q_pop       = load && q_valid;
    empty       = !cur_valid;
    out_byte    = cur.bytes[idx];
    end_of_text = cur.term && at_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      cur_valid <= q_valid;
      idx       <= '0;
    end else if (pop) begin
      idx <= idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_job;
  end

endmodule

@@ rtl/wide_char_to_utf8_encoder.sv @@
// Top level: wide code unit (UTF-16 / UTF-32) to UTF-8 byte stream encoder.
`timescale 1ns / 1ps
//
//  Channel   Handshake               Payload
//  -------   ---------------------   ------------------------------------
//  input     push / full             code_unit[31:0], last_unit
//  result    empty / pop             out_byte[7:0], end_of_text
//  config    unit_mode_we            unit_mode_wdata (0 = UTF-16, 1 = UTF-32)
//
//  The front end takes one unit per cycle while the job queue has room; the
//  serialiser emits one byte per cycle while popped, and a unit yields 0 to 7
//  result bytes (typically 1..4, plus 3 for a flushed surrogate and 1
//  for the terminator). Sustained rate is set by the one-byte result port.
//  Either side may stall; the two-entry job queue decouples them.
//  Reset (rst, synchronous) empties the queue and clears surrogate and
//  string state; mode returns to UTF-16.
//
module wide_char_to_utf8_encoder (
  input  logic        clk,
  input  logic        rst,
  // config
  input  logic        unit_mode_we,
  input  logic        unit_mode_wdata,
  // input transactions
  input  logic        push,
  output logic        full,
  input  logic [31:0] code_unit,
  input  logic        last_unit,
  // result transactions
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        end_of_text
);

  wctu_pkg::job_t job, q_job;
  logic           job_push, q_valid, q_pop, in_take;

  // a unit is taken whenever the queue can hold its job
  assign in_take = push && !full;

  wctu_front u_front (
    .clk             (clk),
    .rst             (rst),
    .unit_mode_we    (unit_mode_we),
    .unit_mode_wdata (unit_mode_wdata),
    .in_take         (in_take),
    .code_unit       (code_unit),
    .last_unit       (last_unit),
    .job_push        (job_push),
    .job             (job)
  );

  wctu_jobq u_jobq (
    .clk      (clk),
    .rst      (rst),
    .push     (job_push),
    .push_job (job),
    .full     (full),
    .pop      (q_pop),
    .q_valid  (q_valid),
    .q_job    (q_job)
  );

  wctu_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_job       (q_job),
    .q_pop       (q_pop),
    .out_byte    (out_byte),
    .end_of_text (end_of_text),
    .empty       (empty),
    .pop         (pop)
  );

endmodule

@@ rtl/wctu_chk.sv @@
// Checker: port-level properties of the encoder, bound to the top level.
`timescale 1ns / 1ps
module wctu_chk (
  input logic        clk,
  input logic        rst,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [7:0]  out_byte,
  input logic        end_of_text
);

  a_empty_after_rst: assert property (@(posedge clk) rst |=> empty)
    else $error("result side not empty after reset");

  a_room_after_rst: assert property (@(posedge clk) rst |=> !full)
    else $error("input side full after reset");

  a_term_is_nul: assert property (@(posedge clk) disable iff (rst)
    (!empty && end_of_text) |-> (out_byte == 8'h00))
    else $error("terminator byte not zero");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(end_of_text)))
    else $error("waiting result changed");

endmodule

bind wide_char_to_utf8_encoder wctu_chk u_chk (
  .clk         (clk),
  .rst         (rst),
  .full        (full),
  .empty       (empty),
  .pop         (pop),
  .out_byte    (out_byte),
  .end_of_text (end_of_text)
);

@@ test/utf8_stream_checker.sv @@
// Checker: predicts the UTF-8 byte stream from accepted units and compares every popped byte.
`timescale 1ns / 1ps
module utf8_stream_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        unit_mode_we,
  input  logic        unit_mode_wdata,
  input  logic        push,
  input  logic        full,
  input  logic [31:0] code_unit,
  input  logic        last_unit,
  input  logic        empty,
  input  logic        pop,
  input  logic [7:0]  out_byte,
  input  logic        end_of_text,
  output int          fail_count,
  output int          bytes_owed
);

  localparam logic [31:0] ONE_BYTE_LIMIT = 32'h80;
  localparam logic [31:0] TWO_BYTE_LIMIT = 32'h800;
  localparam logic [7:0]  TERMINATOR     = 8'h00;

  typedef struct packed {
    logic [7:0] value;
    logic       eot;
  } utf8_byte_t;

  utf8_byte_t  bytes_due[$];

  // predictor state
  logic        wide_units;   // 1: 32-bit units
  logic [15:0] held_high;
  logic        high_held;
  logic        text_closed;  // NUL seen mid-string, dropping up to the last unit

  task automatic owe_byte(input logic [7:0] value, input logic eot);
    utf8_byte_t b;
    b.value = value;
    b.eot   = eot;
    bytes_due.push_back(b);
  endtask

  task automatic owe_three(input logic [31:0] v);
    owe_byte(wctu_pkg::LEAD3 | v[19:12], 1'b0);
    owe_byte({wctu_pkg::CONT_TAG, v[11:6]}, 1'b0);
    owe_byte({wctu_pkg::CONT_TAG, v[5:0]}, 1'b0);
  endtask

  task automatic owe_four(input logic [31:0] v);
    owe_byte(wctu_pkg::LEAD4 | {5'd0, v[20:18]}, 1'b0);
    owe_byte({wctu_pkg::CONT_TAG, v[17:12]}, 1'b0);
    owe_byte({wctu_pkg::CONT_TAG, v[11:6]}, 1'b0);
    owe_byte({wctu_pkg::CONT_TAG, v[5:0]}, 1'b0);
  endtask

  task automatic owe_short(input logic [31:0] v);
    if (v < ONE_BYTE_LIMIT) begin
      owe_byte(v[7:0], 1'b0);
    end else if (v < TWO_BYTE_LIMIT) begin
      owe_byte({wctu_pkg::LEAD2_TAG, v[10:6]}, 1'b0);
      owe_byte({wctu_pkg::CONT_TAG, v[5:0]}, 1'b0);
    end else begin
      owe_three(v);
    end
  endtask

  task automatic predict_unit(input logic [31:0] raw, input logic last);
    logic [31:0] u;
    logic [20:0] cp;
    if (text_closed) begin
      if (last) text_closed = 1'b0;
      return;
    end
    if (!wide_units) begin
      u = {16'd0, raw[15:0]};
      if (high_held) begin
        high_held = 1'b0;
        if (u[15:10] == wctu_pkg::LOW_SURR_TAG) begin
          cp = wctu_pkg::SUPP_BASE + {1'b0, held_high[9:0], u[9:0]};
          held_high = '0;
          owe_four({11'd0, cp});
          if (last) owe_byte(TERMINATOR, 1'b1);
          return;
        end
        // unpaired high surrogate goes out on its own
        owe_three({16'd0, held_high});
        held_high = '0;
      end
      if (u == '0) begin
        owe_byte(TERMINATOR, 1'b1);
        text_closed = !last;
        return;
      end
      if (u[15:10] == wctu_pkg::HIGH_SURR_TAG && !last) begin
        held_high = u[15:0];
        high_held = 1'b1;
        return;
      end
      owe_short(u);
    end else begin
      u = raw;
      if (u == '0) begin
        owe_byte(TERMINATOR, 1'b1);
        text_closed = !last;
        return;
      end
      if (u[31:16] != '0 && u[31:16] <= wctu_pkg::PLANE_TOP) owe_four(u);
      else owe_short(u);
    end
    if (last) owe_byte(TERMINATOR, 1'b1);
  endtask

  initial begin
    fail_count = 0;
    bytes_owed = 0;
  end

  always @(posedge clk) begin
    utf8_byte_t want;
    if (rst) begin
      wide_units  = 1'b0;
      held_high   = '0;
      high_held   = 1'b0;
      text_closed = 1'b0;
      bytes_due.delete();
    end else begin
      // a mode write drops any held surrogate
      if (unit_mode_we) begin
        wide_units = unit_mode_wdata;
        high_held  = 1'b0;
        held_high  = '0;
      end
      if (push && !full) predict_unit(code_unit, last_unit);
      if (pop && !empty) begin
        if (bytes_due.size() == 0) begin
          $error("out_byte: expected nothing, actual %02h (end_of_text %0b)",
                 out_byte, end_of_text);
          fail_count++;
        end else begin
          want = bytes_due.pop_front();
          if (out_byte !== want.value) begin
            $error("out_byte: expected %02h, actual %02h", want.value, out_byte);
            fail_count++;
          end
          if (end_of_text !== want.eot) begin
            $error("end_of_text: expected %0b, actual %0b", want.eot, end_of_text);
            fail_count++;
          end
        end
      end
    end
    bytes_owed = bytes_due.size();
  end

endmodule

@@ test/wide_char_to_utf8_encoder_tb.sv @@
// Testbench top: drives units and mode writes into the encoder, pops bytes, gives the verdict.
`timescale 1ns / 1ps
module wide_char_to_utf8_encoder_tb;

  localparam logic MODE_UTF16  = 1'b0;
  localparam logic MODE_UTF32  = 1'b1;
  localparam int   CYCLE_LIMIT = 600000;  // watchdog bound on the whole run
  localparam int   SETTLE      = 16;      // cycles left for a unit that makes no byte
  localparam int   PHASES      = 6;
  localparam int   PHASE_UNITS = 56;

  logic        clk;
  logic        rst;
  logic        unit_mode_we;
  logic        unit_mode_wdata;
  logic        push;
  logic        full;
  logic [31:0] code_unit;
  logic        last_unit;
  logic        empty;
  logic        pop;
  logic [7:0]  out_byte;
  logic        end_of_text;

  int          fail_count;
  int          bytes_owed;
  int          cycles;
  int          units_sent;   // units that were not simply dropped
  logic        tx_mode;      // mode last written, for building stimulus
  logic        dropping;     // stimulus-side view: string closed by a NUL
  logic        calm_tx;      // no sender gaps while set
  logic        calm_rx;      // no receiver stalls while set

  wide_char_to_utf8_encoder dut (
    .clk            (clk),
    .rst            (rst),
    .unit_mode_we   (unit_mode_we),
    .unit_mode_wdata(unit_mode_wdata),
    .push           (push),
    .full           (full),
    .code_unit      (code_unit),
    .last_unit      (last_unit),
    .empty          (empty),
    .pop            (pop),
    .out_byte       (out_byte),
    .end_of_text    (end_of_text)
  );

  utf8_stream_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .unit_mode_we   (unit_mode_we),
    .unit_mode_wdata(unit_mode_wdata),
    .push           (push),
    .full           (full),
    .code_unit      (code_unit),
    .last_unit      (last_unit),
    .empty          (empty),
    .pop            (pop),
    .out_byte       (out_byte),
    .end_of_text    (end_of_text),
    .fail_count     (fail_count),
    .bytes_owed     (bytes_owed)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // watchdog: a hung handshake ends the run as a failure
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("wide_char_to_utf8_encoder verification failed");
      $finish;
    end
  end

  // One input transaction. Entered and left on a falling edge; push stays high
  // on exit so that a back-to-back unit needs no second assignment in the step.
  task automatic send_unit(input logic [31:0] unit, input logic last);
    int          gap;
    logic [31:0] eff;
    gap = calm_tx ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push      <= 1'b1;
    code_unit <= unit;
    last_unit <= last;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
    // track the drop window so that ignored units are not counted
    eff = (tx_mode == MODE_UTF16) ? {16'd0, unit[15:0]} : unit;
    if (dropping) begin
      if (last) dropping = 1'b0;
    end else begin
      units_sent++;
      if (eff == '0 && !last) dropping = 1'b1;
    end
    if ($urandom_range(0, 31) == 0) calm_tx = !calm_tx;
  endtask

  // Hold off until every owed byte has been popped, then let a held unit settle.
  task automatic drain;
    push <= 1'b0;
    while (bytes_owed != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_mode(input logic m);
    drain();
    unit_mode_we    <= 1'b1;
    unit_mode_wdata <= m;
    tx_mode          = m;
    @(negedge clk);
    unit_mode_we    <= 1'b0;
  endtask

  // One character of random content; a surrogate pair spans two units.
  // Junk in the upper half exercises the ignored bits of 16-bit mode.
  task automatic send_char(input logic closing);
    int          pick;
    logic [15:0] junk;
    logic [15:0] lo;
    pick = $urandom_range(0, 99);
    junk = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'h0;
    if (tx_mode == MODE_UTF16) begin
      if (pick < 25) begin
        lo = 16'($urandom_range(1, 'h7F));
        send_unit({junk, lo}, closing);
      end else if (pick < 45) begin
        lo = 16'($urandom_range('h80, 'h7FF));
        send_unit({junk, lo}, closing);
      end else if (pick < 65) begin
        lo = ($urandom_range(0, 1) == 0) ? 16'($urandom_range('h800, 'hD7FF))
                                         : 16'($urandom_range('hE000, 'hFFFF));
        send_unit({junk, lo}, closing);
      end else if (pick < 88) begin
        send_unit({junk, wctu_pkg::HIGH_SURR_TAG, 10'($urandom)}, 1'b0);
        send_unit({16'($urandom), wctu_pkg::LOW_SURR_TAG, 10'($urandom)}, closing);
      end else if (pick < 93) begin
        // broken pair: high surrogate sent without a low half of its own
        send_unit({junk, wctu_pkg::HIGH_SURR_TAG, 10'($urandom)}, closing);
      end else if (pick < 97) begin
        send_unit({junk, wctu_pkg::LOW_SURR_TAG, 10'($urandom)}, closing);
      end else begin
        send_unit({junk, 16'h0}, closing);
      end
    end else begin
      if (pick < 20) send_unit(32'($urandom_range(1, 'h7F)), closing);
      else if (pick < 35) send_unit(32'($urandom_range('h80, 'h7FF)), closing);
      else if (pick < 55) send_unit(32'($urandom_range('h800, 'hFFFF)), closing);
      else if (pick < 85) send_unit(32'($urandom_range('h10000, 'h10FFFF)), closing);
      else if (pick < 97) send_unit($urandom(), closing);
      else send_unit(32'h0, closing);
    end
  endtask

  // receiver: random stalls before each pop, with calm stretches
  initial begin
    int stall;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      stall = calm_rx ? 0 : $urandom_range(0, 10);
      if (stall != 0) begin
        pop <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      pop <= 1'b1;
      @(posedge clk);
      while (empty) @(posedge clk);
      @(negedge clk);
      if ($urandom_range(0, 31) == 0) calm_rx = !calm_rx;
    end
  end

  initial begin
    int len;
    int goal;
    rst             = 1'b1;
    push            = 1'b0;
    pop             = 1'b0;
    code_unit       = '0;
    last_unit       = 1'b0;
    unit_mode_we    = 1'b0;
    unit_mode_wdata = 1'b0;
    tx_mode         = MODE_UTF16;
    dropping        = 1'b0;
    calm_tx         = 1'b0;
    calm_rx         = 1'b0;
    units_sent      = 0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // --- directed, 16-bit units ---
    set_mode(MODE_UTF16);
    send_unit(32'h0000_0000, 1'b1);     // empty string: terminator only
    send_unit(32'h0000_007F, 1'b0);     // byte-count boundaries
    send_unit(32'h0000_0080, 1'b0);
    send_unit(32'h0000_07FF, 1'b0);
    send_unit(32'h0000_0800, 1'b0);
    send_unit(32'h0000_FFFF, 1'b1);
    send_unit(32'h0000_D800, 1'b0);     // lowest pair
    send_unit(32'h0000_DC00, 1'b0);
    send_unit(32'h0000_DBFF, 1'b0);     // highest pair, last on the low half
    send_unit(32'h0000_DFFF, 1'b1);
    send_unit(32'h0000_D83D, 1'b0);     // held high flushed by a plain unit
    send_unit(32'hFFFF_0041, 1'b0);     // upper half ignored
    send_unit(32'h0000_DC00, 1'b1);     // lone low, last
    send_unit(32'h0000_D800, 1'b0);     // held high then NUL mid-string
    send_unit(32'h0000_0000, 1'b0);
    send_unit(32'h0000_0041, 1'b0);     // dropped
    send_unit(32'h0000_DBFF, 1'b1);     // dropped, reopens the string
    send_unit(32'h0000_DBFF, 1'b1);     // trailing high surrogate, unpaired
    send_unit(32'h0000_D801, 1'b0);     // held high then a last plain unit
    send_unit(32'h0000_0042, 1'b1);
    send_unit(32'h0000_DABC, 1'b0);     // held high discarded by a mode write
    set_mode(MODE_UTF16);
    send_unit(32'h0000_0043, 1'b1);

    // --- directed, 32-bit units ---
    set_mode(MODE_UTF32);
    send_unit(32'h0001_0000, 1'b0);
    send_unit(32'h0010_FFFF, 1'b0);
    send_unit(32'h0000_DFFF, 1'b0);     // surrogate value: plain three bytes
    send_unit(32'h0011_0000, 1'b0);     // beyond the code space
    send_unit(32'hFFFF_FFFF, 1'b1);
    send_unit(32'h0000_0000, 1'b0);     // NUL mid-string, then a dropped last
    send_unit(32'h0000_0001, 1'b1);

    // --- random strings, alternating modes ---
    for (int phase = 0; phase < PHASES; phase++) begin
      set_mode(phase[0] ? MODE_UTF32 : MODE_UTF16);
      goal = units_sent + PHASE_UNITS;
      while (units_sent < goal) begin
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++) send_char(i == len - 1);
        // now and then let the pipeline run dry before carrying on
        if ($urandom_range(0, 15) == 0) drain();
      end
      // sometimes leave a high surrogate held across the mode write
      if (tx_mode == MODE_UTF16 && $urandom_range(0, 1) == 1)
        send_unit({16'($urandom), wctu_pkg::HIGH_SURR_TAG, 10'($urandom)}, 1'b0);
    end

    drain();
    if (fail_count == 0) begin
      $display("wide_char_to_utf8_encoder verification clean");
    end else begin
      $display("wide_char_to_utf8_encoder verification failed");
    end
    $finish;
  end

endmodule
